[hdl/lst_pkg.sv]
package lst_pkg;

    // one arriving beat
    typedef struct packed {
        logic        packet_valid;
        logic [15:0] src_port;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [31:0] now_secs;
    } t_in_item;

    // one result beat
    typedef struct packed {
        logic [5:0] slot;
        logic [1:0] status;
        logic [6:0] expired_count;
        logic [6:0] active_count;
    } t_out_item;

    // stored client key
    typedef struct packed {
        logic [15:0] port;
        logic [63:0] high;
        logic [63:0] low;
    } t_key;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LRD,
        S_LCMP,
        S_NEW,
        S_HIT1,
        S_HIT2,
        S_ECHK,
        S_ECMP,
        S_OUT
    } t_state;

    localparam logic [1:0] ST_HIT  = 2'd0;
    localparam logic [1:0] ST_NEW  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_NONE = 2'd3;

    localparam logic [31:0] LIFE_RESET = 32'd60;

endpackage

[hdl/lru_session_table_with_expiry_unit.sv]
// Client session table with LRU order and idle expiry.
// Input channel: i_in_valid / o_in_stall carry one t_in_item per beat, taken
// at an edge with valid high and stall low. Output channel: o_out_valid /
// i_out_stall carry exactly one t_out_item per input beat, in order.
// The lifetime register is written through i_cfg_we / i_cfg_data; the user
// writes it only while idle, as the block itself does not enforce this.
// Each beat is handled alone by a sequencer around simple dual-port memories
// (keys, last-seen, next/prev links, free stack), each read registered.
// The lookup walks the list from the head, up to the active count; a new
// slot is linked at the head, a hit off the head is unlinked and relinked at
// the head, and unless expiry is off the tail walk then expires stale
// entries until it meets a live entry or empties the table.
// The result sits in an output register; the next input beat is taken once
// the result is loaded, even if the receiver stalls it. While the receiver
// stalls, the result holds and a finished next beat waits in the sequencer.
// Reset empties the table, puts all slots on the free stack with slot 0 on
// top and sets the lifetime to 60 seconds; no clearing pass is needed.
module lru_session_table_with_expiry_unit
    import lst_pkg::*;
#(
    parameter int MAX_CLIENTS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    input  logic      i_cfg_we,
    input  logic [31:0] i_cfg_data
);

    localparam int AW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int CW = $clog2(MAX_CLIENTS + 1);
    localparam logic [CW-1:0] NCLI = CW'(MAX_CLIENTS);

    // memories
    t_key          m_key  [MAX_CLIENTS];
    logic [31:0]   m_ls   [MAX_CLIENTS];
    logic [AW-1:0] m_nx   [MAX_CLIENTS];
    logic [AW-1:0] m_pv   [MAX_CLIENTS];
    logic [AW-1:0] m_fs   [MAX_CLIENTS];

    t_key          r_key_q;
    logic [31:0]   r_ls_q;
    logic [AW-1:0] r_nx_q, r_pv_q, r_fs_q;

    // control registers
    t_state        r_state, n_state;
    t_in_item      r_item, n_item;
    logic [31:0]   r_life, n_life;
    logic [31:0]   r_before, n_before;
    logic          r_exp_en, n_exp_en;
    logic [AW-1:0] r_head, n_head, r_tail, n_tail;
    logic [AW-1:0] r_cur, n_cur, r_p, n_p, r_n, n_n, r_slot, n_slot;
    logic [CW-1:0] r_fc, n_fc, r_low, n_low, r_steps, n_steps, r_exp, n_exp;
    logic [1:0]    r_status, n_status;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out, n_out;

    // memory ports
    logic [AW-1:0] rd_addr;
    logic          fs_re;
    logic [AW-1:0] fs_ra;
    logic          key_we, ls_we, nx_we, pv_we, fs_we;
    logic [AW-1:0] key_wa, ls_wa, nx_wa, pv_wa, fs_wa;
    logic [AW-1:0] nx_wd, pv_wd, fs_wd;

    logic [CW-1:0] active;
    logic [CW-1:0] pop_idx;
    logic [AW-1:0] pop_slot;
    logic          key_match;

    assign active    = NCLI - r_fc;
    assign pop_idx   = r_fc - CW'(1);
    assign pop_slot  = (pop_idx < r_low) ? AW'(NCLI - CW'(1) - pop_idx) : r_fs_q;
    assign key_match = (r_key_q.port == r_item.src_port) &&
                       (r_key_q.high == r_item.addr_high) &&
                       (r_key_q.low == r_item.addr_low);

    // memory access
    always_ff @(posedge i_clk) begin
        r_key_q <= m_key[rd_addr];
        r_ls_q  <= m_ls[rd_addr];
        r_nx_q  <= m_nx[rd_addr];
        r_pv_q  <= m_pv[rd_addr];
        if (fs_re) begin
            r_fs_q <= m_fs[fs_ra];
        end
        if (key_we) begin
            m_key[key_wa] <= t_key'{r_item.src_port, r_item.addr_high, r_item.addr_low};
        end
        if (ls_we) begin
            m_ls[ls_wa] <= r_item.now_secs;
        end
        if (nx_we) begin
            m_nx[nx_wa] <= nx_wd;
        end
        if (pv_we) begin
            m_pv[pv_wa] <= pv_wd;
        end
        if (fs_we) begin
            m_fs[fs_wa] <= fs_wd;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;   n_item = r_item;     n_life = r_life;
        n_before = r_before; n_exp_en = r_exp_en; n_head = r_head;
        n_tail = r_tail;     n_cur = r_cur;       n_p = r_p;
        n_n = r_n;           n_slot = r_slot;     n_fc = r_fc;
        n_low = r_low;       n_steps = r_steps;   n_exp = r_exp;
        n_status = r_status; n_out = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        rd_addr = r_cur;
        fs_re = 1'b0;  fs_ra = pop_idx[AW-1:0];
        key_we = 1'b0; key_wa = r_slot;
        ls_we = 1'b0;  ls_wa = r_slot;
        nx_we = 1'b0;  nx_wa = r_slot; nx_wd = r_head;
        pv_we = 1'b0;  pv_wa = r_head; pv_wd = r_slot;
        fs_we = 1'b0;  fs_wa = r_fc[AW-1:0]; fs_wd = r_tail;
        o_in_stall = (r_state != S_IDLE);

        if (i_cfg_we) begin
            n_life = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item   = i_in_item;
                    n_exp    = '0;
                    n_slot   = '0;
                    n_exp_en = (i_in_item.now_secs >= r_life);
                    n_before = i_in_item.now_secs - r_life;
                    fs_re    = (r_fc != '0);
                    if (!i_in_item.packet_valid) begin
                        n_status = ST_NONE;
                        n_state  = S_ECHK;
                    end else if (active != '0) begin
                        n_cur   = r_head;
                        n_steps = '0;
                        n_state = S_LRD;
                    end else begin
                        n_state = S_NEW;
                    end
                end
            end
            S_LRD: begin
                n_state = S_LCMP;
            end
            S_LCMP: begin
                // compare one list entry against the key
                if (key_match) begin
                    n_slot   = r_cur;
                    n_status = ST_HIT;
                    n_p      = r_pv_q;
                    n_n      = r_nx_q;
                    if (r_cur == r_head) begin
                        ls_we   = 1'b1;
                        ls_wa   = r_cur;
                        n_state = S_ECHK;
                    end else begin
                        n_state = S_HIT1;
                    end
                end else if (r_steps == active - CW'(1)) begin
                    if (r_fc == '0) begin
                        n_status = ST_FULL;
                        n_slot   = '0;
                        n_state  = S_ECHK;
                    end else begin
                        n_state = S_NEW;
                    end
                end else begin
                    n_cur   = r_nx_q;
                    n_steps = r_steps + CW'(1);
                    n_state = S_LRD;
                end
            end
            S_NEW: begin
                // pop a free slot and link it at the head
                if (r_fc == '0) begin
                    n_status = ST_FULL;
                    n_slot   = '0;
                end else begin
                    n_status = ST_NEW;
                    n_slot   = pop_slot;
                    n_fc     = pop_idx;
                    if (pop_idx < r_low) begin
                        n_low = pop_idx;
                    end
                    key_we = 1'b1; key_wa = pop_slot;
                    ls_we  = 1'b1; ls_wa  = pop_slot;
                    n_head = pop_slot;
                    if (active == '0) begin
                        n_tail = pop_slot;
                    end else begin
                        nx_we = 1'b1; nx_wa = pop_slot; nx_wd = r_head;
                        pv_we = 1'b1; pv_wa = r_head;   pv_wd = pop_slot;
                    end
                end
                n_state = S_ECHK;
            end
            S_HIT1: begin
                // unlink the hit slot
                nx_we = 1'b1; nx_wa = r_p; nx_wd = r_n;
                if (r_slot == r_tail) begin
                    n_tail = r_p;
                end else begin
                    pv_we = 1'b1; pv_wa = r_n; pv_wd = r_p;
                end
                ls_we   = 1'b1;
                n_state = S_HIT2;
            end
            S_HIT2: begin
                // relink it at the head
                nx_we  = 1'b1;
                pv_we  = 1'b1;
                n_head = r_slot;
                n_state = S_ECHK;
            end
            S_ECHK: begin
                rd_addr = r_tail;
                if (r_exp_en && active != '0) begin
                    n_state = S_ECMP;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_ECMP: begin
                // expire the tail if it is stale
                if (r_ls_q < r_before) begin
                    if (active > CW'(1)) begin
                        n_tail = r_pv_q;
                    end
                    fs_we   = 1'b1;
                    n_fc    = r_fc + CW'(1);
                    n_exp   = r_exp + CW'(1);
                    n_state = S_ECHK;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid         = 1'b1;
                    n_out.slot          = 6'(r_slot);
                    n_out.status        = r_status;
                    n_out.expired_count = 7'(r_exp);
                    n_out.active_count  = 7'(active);
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_life      <= LIFE_RESET;
            r_head      <= '0;
            r_tail      <= '0;
            r_fc        <= NCLI;
            r_low       <= NCLI;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_life      <= n_life;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fc        <= n_fc;
            r_low       <= n_low;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_before <= n_before;
        r_exp_en <= n_exp_en;
        r_cur    <= n_cur;
        r_p      <= n_p;
        r_n      <= n_n;
        r_slot   <= n_slot;
        r_steps  <= n_steps;
        r_exp    <= n_exp;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // checks
    a_fc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fc <= NCLI) else $error("free count above table size");
    a_low_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_fc) else $error("free stack low mark above free count");
    a_full_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (r_status == ST_FULL || r_status == ST_NONE))
        |-> r_slot == '0) else $error("dropped beat carries a slot");

endmodule
